### rtl/npcm_pkg.sv
// ----------------------------------------------------------------------------
// npcm_pkg
// Palette table, register map and shared types for the palette color matcher.
// ----------------------------------------------------------------------------
package npcm_pkg;

    localparam int NumEntries = 255;
    localparam int IdxW       = 8;
    localparam int DistW      = 18;  // 3 * 255^2 < 2^18

    localparam logic [0:0] RegInkMode = 1'b0;

    typedef logic [IdxW-1:0] t_idx;
    typedef logic [DistW-1:0] t_dist;

    // word handed from one cell to the next
    typedef struct packed {
        logic       vld;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        t_dist      best_d;
        t_idx       best_i;
        logic       forced;
    } t_link;

    function automatic logic [7:0] chan_byte(input int v, input int k);
        int t;
        begin
            t = (v * k * 51 + 8) / 16;
            return t[7:0];
        end
    endfunction

    function automatic logic [23:0] palette_entry(input int idx);
        int k, hue, step, sat, v, sector, f, kp, kq, kt, kr, kg, kb;
        int vt [5];
        logic [23:0] fx [10];
        logic [23:0] gr [6];
        begin
            vt = '{10, 8, 6, 5, 3};
            fx = '{24'h000000, 24'hFF0000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF,
                   24'h0000FF, 24'hFF00FF, 24'hFFFFFF, 24'h808080, 24'hC0C0C0};
            gr = '{24'h333333, 24'h505050, 24'h696969, 24'h828282, 24'hBEBEBE,
                   24'hFFFFFF};
            if (idx >= 1 && idx <= 9) return fx[idx];
            if (idx >= 250 && idx <= 255) return gr[idx-250];
            if (idx < 10 || idx > 255) return 24'h0;
            k = idx - 10;
            hue = k / 10;
            step = (k % 10) / 2;
            sat = ((k % 2) == 1) ? 1 : 2;
            v = vt[step];
            sector = (hue / 4) % 6;
            f = hue % 4;
            kp = 4 * (2 - sat);
            kq = 8 - sat * f;
            kt = 8 - sat * (4 - f);
            case (sector)
                0: begin kr = 8;  kg = kt; kb = kp; end
                1: begin kr = kq; kg = 8;  kb = kp; end
                2: begin kr = kp; kg = 8;  kb = kt; end
                3: begin kr = kp; kg = kq; kb = 8;  end
                4: begin kr = kt; kg = kp; kb = 8;  end
                default: begin kr = 8; kg = kp; kb = kq; end
            endcase
            return {chan_byte(v, kr), chan_byte(v, kg), chan_byte(v, kb)};
        end
    endfunction

endpackage

### rtl/npcm_cell.sv
// ----------------------------------------------------------------------------
// npcm_cell
// One palette entry: distance to the passing color, keeps the nearer candidate.
// ----------------------------------------------------------------------------
module npcm_cell import npcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [23:0] i_entry,
    input  t_idx        i_index,
    input  t_link       i_link,
    output t_link       o_link
);

    t_link r_link;
    t_link n_link;
    logic [7:0] dr, dg, db;
    t_dist      cand_d;

    always_comb begin
        dr = (i_link.red > i_entry[23:16]) ? i_link.red - i_entry[23:16]
                                           : i_entry[23:16] - i_link.red;
        dg = (i_link.green > i_entry[15:8]) ? i_link.green - i_entry[15:8]
                                            : i_entry[15:8] - i_link.green;
        db = (i_link.blue > i_entry[7:0]) ? i_link.blue - i_entry[7:0]
                                          : i_entry[7:0] - i_link.blue;
        cand_d = DistW'({8'd0, dr} * {8'd0, dr}) + DistW'({8'd0, dg} * {8'd0, dg})
               + DistW'({8'd0, db} * {8'd0, db});
        n_link = i_link;
        // strict compare keeps the lowest index on ties
        if (!i_link.forced && cand_d < i_link.best_d) begin
            n_link.best_d = cand_d;
            n_link.best_i = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.vld <= 1'b0;
        end else begin
            r_link.vld <= i_link.vld;
        end
        r_link.red    <= n_link.red;
        r_link.green  <= n_link.green;
        r_link.blue   <= n_link.blue;
        r_link.best_d <= n_link.best_d;
        r_link.best_i <= n_link.best_i;
        r_link.forced <= n_link.forced;
    end

    assign o_link = r_link;

endmodule

### rtl/nearest_palette_color_match.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_match
// Nearest-entry lookup of an RGB color in a fixed 255-entry palette.
// ----------------------------------------------------------------------------
// A color is taken every cycle (o_busy stays low) and passes a row of 255
// cells, one per palette entry, one cell per cycle; its index appears with
// o_valid from the register of the last cell, in input order. Results cannot
// be stalled. ink_mode lives at byte address 0 of the APB port.
module nearest_palette_color_match import npcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_color,
    output logic        o_busy,
    output logic        o_valid,
    output logic [7:0]  o_palette_index,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [0:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic  r_ink_mode;
    t_link links [NumEntries+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ink_mode <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite && i_paddr == RegInkMode) begin
            r_ink_mode <= i_pwdata[0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == RegInkMode) ? {31'd0, r_ink_mode} : 32'd0;
    assign o_busy   = 1'b0;

    always_comb begin
        links[0].vld    = i_start;
        links[0].red    = i_color[23:16];
        links[0].green  = i_color[15:8];
        links[0].blue   = i_color[7:0];
        links[0].forced = r_ink_mode && (i_color == 24'd0);
        links[0].best_d = '1;
        links[0].best_i = 8'd7;
    end

    for (genvar g = 0; g < NumEntries; g++) begin : g_cell
        npcm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_entry (palette_entry(g + 1)),
            .i_index (t_idx'(g + 1)),
            .i_link  (links[g]),
            .o_link  (links[g+1])
        );
    end

    assign o_valid         = links[NumEntries].vld;
    assign o_palette_index = links[NumEntries].best_i;

endmodule
